/* rtl/core/abpr_pkg.sv */
// ----------------------------------------------------------------------------
// abpr_pkg
// Shared widths, control bundles and the history helper for the aging-bits
// page replacement block.
// ----------------------------------------------------------------------------
package abpr_pkg;

   localparam int PAGE_W  = 8;
   localparam int FRAMES  = 8;
   localparam int FRAME_W = 3;
   localparam int CNT_W   = 4;
   localparam int HIST_W  = 8;
   localparam int FAULT_W = 32;
   localparam int CSR_W   = 4;

   localparam logic [CSR_W-1:0]   CSR_RESET  = CSR_W'(FRAMES);
   localparam logic [FAULT_W-1:0] FAULT_SAT  = '1;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic scan_step;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   typedef logic [HIST_W-1:0][PAGE_W-1:0] tap_pages_type;

   // history of a page: bit HIST_W-1-k is set when the reference k steps ago was pg
   function automatic logic [HIST_W-1:0] page_hist(
      input logic [PAGE_W-1:0] pg,
      input tap_pages_type     taps,
      input logic [HIST_W-1:0] vld
   );
      logic [HIST_W-1:0] h;
      h = '0;
      for (int k = 0; k < HIST_W; k++) begin
         h[HIST_W-1-k] = vld[k] && (taps[k] == pg);
      end
      return h;
   endfunction

endpackage

/* rtl/core/abpr_req_if.sv */
// ----------------------------------------------------------------------------
// abpr_req_if
// Request channel: one page reference per transfer.
// ----------------------------------------------------------------------------
interface abpr_req_if;
   logic                        valid;
   logic                        ready;
   logic [abpr_pkg::PAGE_W-1:0] page;
   logic                        last_reference;

   modport source (output valid, page, last_reference, input ready);
   modport sink   (input valid, page, last_reference, output ready);
endinterface

/* rtl/core/abpr_rsp_if.sv */
// ----------------------------------------------------------------------------
// abpr_rsp_if
// Response channel: outcome of one page reference.
// ----------------------------------------------------------------------------
interface abpr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         fault;
   logic [abpr_pkg::FRAME_W-1:0] frame_slot;
   logic                         evicted_valid;
   logic [abpr_pkg::PAGE_W-1:0]  evicted_page;
   logic [abpr_pkg::FAULT_W-1:0] fault_count;
   logic                         string_done;

   modport source (output valid, fault, frame_slot, evicted_valid, evicted_page,
                   fault_count, string_done, input ready);
   modport sink   (input valid, fault, frame_slot, evicted_valid, evicted_page,
                   fault_count, string_done, output ready);
endinterface

/* rtl/core/aging_bits_page_replacement.sv */
// ----------------------------------------------------------------------------
// aging_bits_page_replacement
// Page replacement with 8-bit aging histories over a small frame table.
//
// req_ch carries one page reference per request (page, last_reference);
// rsp_ch returns fault, frame_slot, evicted page and the running fault count.
// csr_we/csr_wdata set the number of frames in use (0 acts as 1, values
// above the frame count act as the frame count); write it between strings.
// A request is taken only while the block is idle. Hit or free-frame fill:
// the request passes the lookup and commit states; commit loads the response.
// Eviction: a sequential minimum search visits one frame per cycle, taking
// frame 0 at lookup and then frames 1 to n-1 of the n frames in use.
// Histories come from a line of the last 8 references, so aging is free.
// A finished response waits in the output register while the next request
// is accepted; a stalled receiver holds the block before its commit step.
// Synchronous reset empties all frames, histories and the fault count and
// sets 8 frames in use; a request with last_reference does the same, after
// its response, keeping the frame count.
// ----------------------------------------------------------------------------
module aging_bits_page_replacement (
   input  logic                       clock,
   input  logic                       reset,
   abpr_req_if.sink                   req_ch,
   abpr_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [abpr_pkg::CSR_W-1:0] csr_wdata
);

   abpr_pkg::ctl_cmd_type   ctl_cmd;
   abpr_pkg::dp_status_type dp_status;
   logic                    ctl_ready;

   assign req_ch.ready = ctl_ready;

   abpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_ready),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   abpr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_page          (req_ch.page),
      .req_last          (req_ch.last_reference),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_fault         (rsp_ch.fault),
      .rsp_frame_slot    (rsp_ch.frame_slot),
      .rsp_evicted_valid (rsp_ch.evicted_valid),
      .rsp_evicted_page  (rsp_ch.evicted_page),
      .rsp_fault_count   (rsp_ch.fault_count),
      .rsp_string_done   (rsp_ch.string_done),
      .cmd               (ctl_cmd),
      .status            (dp_status)
   );

`ifndef SYNTHESIS
   // one request in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |=> rsp_ch.valid)
      else $error("commit did not produce a response");

   a_no_evict_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.fault |-> !rsp_ch.evicted_valid && (rsp_ch.evicted_page == '0))
      else $error("eviction reported on a hit");

   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |-> !rsp_ch.valid || rsp_ch.ready)
      else $error("response overwritten before it was taken");
`endif

endmodule

/* rtl/core/abpr_ctrl.sv */
// ----------------------------------------------------------------------------
// abpr_ctrl
// Sequencer: capture, lookup, victim scan and commit of one request.
// ----------------------------------------------------------------------------
module abpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  abpr_pkg::dp_status_type status,
   output abpr_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOK   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = status.need_scan ? S_SCAN : S_COMMIT;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            // wait for the response register to drain
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/abpr_dp.sv */
// ----------------------------------------------------------------------------
// abpr_dp
// Frame table, recent-reference line, victim search and response register.
// ----------------------------------------------------------------------------
module abpr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [abpr_pkg::CSR_W-1:0]         csr_wdata,
   input  logic [abpr_pkg::PAGE_W-1:0]        req_page,
   input  logic                               req_last,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_fault,
   output logic [abpr_pkg::FRAME_W-1:0]       rsp_frame_slot,
   output logic                               rsp_evicted_valid,
   output logic [abpr_pkg::PAGE_W-1:0]        rsp_evicted_page,
   output logic [abpr_pkg::FAULT_W-1:0]       rsp_fault_count,
   output logic                               rsp_string_done,
   input  abpr_pkg::ctl_cmd_type              cmd,
   output abpr_pkg::dp_status_type            status
);

   logic [abpr_pkg::CSR_W-1:0]   frames_in_use_ff;
   logic [abpr_pkg::CNT_W-1:0]   active_n;

   logic [abpr_pkg::PAGE_W-1:0]  page_ff;
   logic                         last_ff;

   logic [abpr_pkg::PAGE_W-1:0]  frame_pg_ff [abpr_pkg::FRAMES];
   logic [abpr_pkg::CNT_W-1:0]   filled_ff;
   abpr_pkg::tap_pages_type      tap_pg_ff;
   logic [abpr_pkg::HIST_W-1:0]  tap_vld_ff;
   logic [abpr_pkg::FAULT_W-1:0] faults_ff;

   logic                         hit_ff;
   logic [abpr_pkg::FRAME_W-1:0] slot_ff;
   logic [abpr_pkg::FRAME_W-1:0] best_ff;
   logic [abpr_pkg::PAGE_W-1:0]  best_pg_ff;
   logic [abpr_pkg::HIST_W-1:0]  best_hist_ff;
   logic [abpr_pkg::FRAME_W-1:0] idx_ff;

   logic                         hit_c;
   logic [abpr_pkg::FRAME_W-1:0] slot_c;
   logic                         fill_avail;
   logic [abpr_pkg::PAGE_W-1:0]  scan_pg;
   logic [abpr_pkg::HIST_W-1:0]  scan_hist;
   logic [abpr_pkg::HIST_W-1:0]  first_hist;

   logic                         evict_c;
   logic [abpr_pkg::FRAME_W-1:0] out_slot;
   logic [abpr_pkg::FAULT_W-1:0] faults_nx;

   // out-of-range counts clamp to 1..FRAMES
   always_comb begin
      if (frames_in_use_ff == '0) begin
         active_n = abpr_pkg::CNT_W'(1);
      end else if (abpr_pkg::CNT_W'(frames_in_use_ff) > abpr_pkg::CNT_W'(abpr_pkg::FRAMES)) begin
         active_n = abpr_pkg::CNT_W'(abpr_pkg::FRAMES);
      end else begin
         active_n = abpr_pkg::CNT_W'(frames_in_use_ff);
      end
   end

   // residency check across all filled frames, lowest frame wins
   always_comb begin
      hit_c  = 1'b0;
      slot_c = '0;
      for (int i = abpr_pkg::FRAMES - 1; i >= 0; i--) begin
         if ((abpr_pkg::CNT_W'(i) < filled_ff) && (frame_pg_ff[i] == page_ff)) begin
            hit_c  = 1'b1;
            slot_c = abpr_pkg::FRAME_W'(i);
         end
      end
   end

   assign fill_avail = filled_ff < active_n;
   assign scan_pg    = frame_pg_ff[idx_ff];
   assign scan_hist  = abpr_pkg::page_hist(scan_pg, tap_pg_ff, tap_vld_ff);
   assign first_hist = abpr_pkg::page_hist(frame_pg_ff[0], tap_pg_ff, tap_vld_ff);

   assign status.need_scan = !hit_c && !fill_avail && (active_n > abpr_pkg::CNT_W'(1));
   assign status.scan_last = ({1'b0, idx_ff} == (active_n - abpr_pkg::CNT_W'(1)));
   assign status.out_free  = !rsp_valid || rsp_ready;

   assign evict_c = !hit_ff && !fill_avail;

   always_comb begin
      if (hit_ff) begin
         out_slot = slot_ff;
      end else if (fill_avail) begin
         out_slot = filled_ff[abpr_pkg::FRAME_W-1:0];
      end else begin
         out_slot = best_ff;
      end
   end

   assign faults_nx = (hit_ff || (faults_ff == abpr_pkg::FAULT_SAT)) ? faults_ff
                                                                     : faults_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= abpr_pkg::CSR_RESET;
      end else if (csr_we) begin
         frames_in_use_ff <= csr_wdata;
      end
   end

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff  <= '0;
         tap_vld_ff <= '0;
         faults_ff  <= '0;
      end else begin
         if (cmd.capture) begin
            tap_vld_ff <= {tap_vld_ff[abpr_pkg::HIST_W-2:0], 1'b1};
         end
         if (cmd.commit) begin
            if (last_ff) begin
               filled_ff  <= '0;
               tap_vld_ff <= '0;
               faults_ff  <= '0;
            end else begin
               faults_ff <= faults_nx;
               if (!hit_ff && fill_avail) begin
                  filled_ff <= filled_ff + 1'b1;
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff   <= req_page;
         last_ff   <= req_last;
         tap_pg_ff <= {tap_pg_ff[abpr_pkg::HIST_W-2:0], req_page};
      end
      if (cmd.lookup) begin
         hit_ff       <= hit_c;
         slot_ff      <= slot_c;
         best_ff      <= '0;
         best_pg_ff   <= frame_pg_ff[0];
         best_hist_ff <= first_hist;
         idx_ff       <= abpr_pkg::FRAME_W'(1);
      end
      if (cmd.scan_step) begin
         // strict less-than keeps the lowest frame on ties
         if (scan_hist < best_hist_ff) begin
            best_ff      <= idx_ff;
            best_pg_ff   <= scan_pg;
            best_hist_ff <= scan_hist;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.commit && !hit_ff) begin
         frame_pg_ff[out_slot] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_fault         <= !hit_ff;
         rsp_frame_slot    <= out_slot;
         rsp_evicted_valid <= evict_c;
         rsp_evicted_page  <= evict_c ? best_pg_ff : '0;
         rsp_fault_count   <= faults_nx;
         rsp_string_done   <= last_ff;
      end
   end

endmodule
